### sv/e2q_pkg.sv
package e2q_pkg;

  typedef struct packed {
    logic signed [23:0] angle_x;
    logic signed [23:0] angle_y;
    logic signed [23:0] angle_z;
  } e2q_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } e2q_out_t;

  localparam int unsigned AngleW = 24;
  localparam int unsigned OutW   = 16;
  localparam int unsigned CordW  = 33;
  localparam logic signed [CordW-1:0] CordicGainQ30 = 33'sd652032874;
  localparam logic signed [CordW-1:0] Q30Half = 33'sd536870912;

  localparam logic [31:0] AtanTurns [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  // One CORDIC cell state for one angle.
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic [1:0]              quad;
  } e2q_rot_t;

endpackage

### sv/euler_to_quaternion_unit.sv
// Pipeline: CORDIC_STAGES + 8 register stages, all advancing together.
// Throughput: one transaction per cycle while the output is not stalled; the
// pipeline advances when the output register is empty or being taken, so a new
// angle triple enters every cycle that the output is not held.
// Reset: rst (synchronous, active high) clears the valid bits of every stage;
// datapath registers are not reset.
module euler_to_quaternion_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = 8,
  parameter int unsigned OUT_FRAC_BITS   = 14,
  parameter int unsigned CORDIC_STAGES   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  e2q_pkg::e2q_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output e2q_pkg::e2q_out_t out_data
);
  import e2q_pkg::*;

  // Stages: 2 reduce, CORDIC_STAGES cells, 6 combine (incl. output register).
  localparam int unsigned Depth = CORDIC_STAGES + 8;

  logic             adv;
  logic [Depth-1:0] vld;

  // Advance the whole chain unless the last stage holds an untaken result.
  assign adv       = !vld[Depth-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  e2q_rot_t chain [3][CORDIC_STAGES+1];

  // Angle order: Y first factor, X second, Z third.
  e2q_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_y (
    .clk(clk), .en(adv), .angle(in_data.angle_y), .rot(chain[0][0]));
  e2q_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_x (
    .clk(clk), .en(adv), .angle(in_data.angle_x), .rot(chain[1][0]));
  e2q_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_red_z (
    .clk(clk), .en(adv), .angle(in_data.angle_z), .rot(chain[2][0]));

  // Row of rotation cells, one per CORDIC iteration, for each angle.
  for (genvar a = 0; a < 3; a++) begin : g_ang
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      e2q_cell #(.IDX(i)) u_cell (
        .clk(clk), .en(adv), .din(chain[a][i]), .dout(chain[a][i+1]));
    end
  end

  e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
    .clk(clk), .en(adv),
    .r1(chain[0][CORDIC_STAGES]), .r2(chain[1][CORDIC_STAGES]),
    .r3(chain[2][CORDIC_STAGES]), .dout(out_data));
endmodule

### sv/e2q_reduce.sv
// Reduce a raw angle (taken as the half angle) to quadrant and CORDIC residual.
// Stage 1: bias by whole turns and divide by 45 with a reciprocal multiply.
// Stage 2: remainder lookup, scale to binary angle, split into quadrant and residual.
module e2q_reduce #(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [e2q_pkg::AngleW-1:0]   angle,
  output e2q_pkg::e2q_rot_t                   rot
);
  import e2q_pkg::*;

  // One turn of the half angle is Modulus = 45 * 2^(ANGLE_FRAC_BITS+4) raw units,
  // so the binary angle is floor((r * 2^FracSh + 22) / 45) modulo 2^32.
  localparam longint unsigned Modulus = 64'd360 << (ANGLE_FRAC_BITS + 1);
  localparam longint unsigned Bias    =
      Modulus * ((64'd8388608 + Modulus - 64'd1) / Modulus);
  localparam int unsigned     FracSh  = 28 - ANGLE_FRAC_BITS;
  localparam logic [25:0]     Recip45 = 26'd47721859;

  logic [24:0] u_sum;
  logic [50:0] u_prod;
  logic [24:0] u_q;
  logic [19:0] a_q;
  logic [5:0]  b_idx;
  logic [31:0] frac_tab [45];
  logic [31:0] t_turn;
  logic [31:0] t_off;

  // Whole turns added here only move the binary angle by multiples of 2^32.
  assign u_sum  = 25'(longint'(angle) + longint'(Bias));
  assign u_prod = 51'(u_sum) * 51'(Recip45);

  always_ff @(posedge clk) begin
    if (en) begin
      u_q <= u_sum;
      a_q <= u_prod[50:31];
    end
  end

  for (genvar k = 0; k < 45; k++) begin : g_frac
    localparam longint unsigned FracK = ((longint'(k) << FracSh) + 64'd22) / 64'd45;
    assign frac_tab[k] = FracK[31:0];
  end

  assign b_idx  = 6'(u_q - 25'(a_q) * 25'd45);
  assign t_turn = (32'(a_q) << FracSh) + frac_tab[b_idx];
  assign t_off  = t_turn + 32'h20000000;

  always_ff @(posedge clk) begin
    if (en) begin
      rot.x    <= CordicGainQ30;
      rot.y    <= '0;
      rot.z    <= $signed({3'b000, t_off[29:0]}) - Q30Half;
      rot.quad <= t_off[31:30];
    end
  end
endmodule

### sv/e2q_cell.sv
// One CORDIC rotation cell; handed to the next cell each cycle that en is high.
module e2q_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  e2q_pkg::e2q_rot_t din,
  output e2q_pkg::e2q_rot_t dout
);
  import e2q_pkg::*;

  logic signed [CordW-1:0] xs;
  logic signed [CordW-1:0] ys;
  logic signed [CordW-1:0] at;

  assign xs = din.x >>> IDX;
  assign ys = din.y >>> IDX;
  assign at = $signed({1'b0, AtanTurns[IDX]});

  always_ff @(posedge clk) begin
    if (en) begin
      dout.quad <= din.quad;
      if (!din.z[CordW-1]) begin
        dout.x <= din.x - ys;
        dout.y <= din.y + xs;
        dout.z <= din.z - at;
      end else begin
        dout.x <= din.x + ys;
        dout.y <= din.y - xs;
        dout.z <= din.z + at;
      end
    end
  end
endmodule

### sv/e2q_combine.sv
// Quadrant map, triple products and output rounding/saturation.
module e2q_combine #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              en,
  input  e2q_pkg::e2q_rot_t r1,
  input  e2q_pkg::e2q_rot_t r2,
  input  e2q_pkg::e2q_rot_t r3,
  output e2q_pkg::e2q_out_t dout
);
  import e2q_pkg::*;

  localparam int unsigned Sh = 60 - OUT_FRAC_BITS;

  typedef logic signed [CordW-1:0] cv_t;
  typedef logic signed [65:0]      p_t;

  cv_t c1, s1, c2, s2, c3, s3;
  cv_t c1r, s1r, c2r, s2r, c3r, s3r, c3d, s3d;
  p_t  pcc, pss, pcs, psc;
  cv_t acc, ass, acs, asc;
  p_t  t0a, t0b, t1a, t1b, t2a, t2b, t3a, t3b;
  p_t  sw, sx, sy, sz;

  function automatic void qmap(input e2q_rot_t r, output cv_t c, output cv_t s);
    case (r.quad)
      2'd0: begin c = r.x;  s = r.y;  end
      2'd1: begin c = -r.y; s = r.x;  end
      2'd2: begin c = -r.x; s = -r.y; end
      default: begin c = r.y; s = -r.x; end
    endcase
  endfunction

  function automatic cv_t rnd30(input p_t p);
    p_t v;
    v = (p + p_t'(Q30Half)) >>> 30;
    return CordW'(v);
  endfunction

  function automatic logic signed [15:0] fin(input p_t q);
    p_t v;
    p_t lim;
    v = (q + (p_t'(1) <<< (Sh - 1))) >>> Sh;
    lim = p_t'(1) <<< OUT_FRAC_BITS;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  always_comb begin
    qmap(r1, c1, s1);
    qmap(r2, c2, s2);
    qmap(r3, c3, s3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1r <= c1; s1r <= s1; c2r <= c2; s2r <= s2; c3r <= c3; s3r <= s3;
      pcc <= p_t'(c1r) * p_t'(c2r);
      pss <= p_t'(s1r) * p_t'(s2r);
      pcs <= p_t'(c1r) * p_t'(s2r);
      psc <= p_t'(s1r) * p_t'(c2r);
      c3d <= c3r; s3d <= s3r;
      acc <= rnd30(pcc); ass <= rnd30(pss); acs <= rnd30(pcs); asc <= rnd30(psc);
    end
  end

  cv_t c3e, s3e;
  always_ff @(posedge clk) begin
    if (en) begin
      c3e <= c3d; s3e <= s3d;
      t0a <= p_t'(acc) * p_t'(c3e); t0b <= p_t'(ass) * p_t'(s3e);
      t1a <= p_t'(acs) * p_t'(c3e); t1b <= p_t'(asc) * p_t'(s3e);
      t2a <= p_t'(asc) * p_t'(c3e); t2b <= p_t'(acs) * p_t'(s3e);
      t3a <= p_t'(acc) * p_t'(s3e); t3b <= p_t'(ass) * p_t'(c3e);
      sw <= t0a - t0b; sx <= t1a - t1b; sy <= t2a + t2b; sz <= t3a + t3b;
      dout.quat_w <= fin(sw);
      dout.quat_x <= fin(sx);
      dout.quat_y <= fin(sy);
      dout.quat_z <= fin(sz);
    end
  end
endmodule
